// ===== sv/lkt_pkg.sv =====
// Shared types and constants for the least-recently-used key tracker.
package lkt_pkg;

	localparam int KEY_W = 32;
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Control that the top level broadcasts to every cell in the row.
	typedef struct packed {
		logic upd;  // apply the pending access to the row this cycle
		logic miss; // the pending access found no matching key
	} lkt_ctrl_t;

endpackage

// ===== sv/lkt_cell.sv =====
// One slot of the recency row: holds a key, compares it and shifts from its neighbour.
module lkt_cell
	import lkt_pkg::*;
#(
	parameter int IDX = 0,
	parameter int CW  = 5,
	parameter int PW  = 4
) (
	input  logic             clk,
	input  lkt_ctrl_t        ctrl,
	input  logic [CW-1:0]    count,
	input  logic [PW-1:0]    hit_pos,
	input  logic [KEY_W-1:0] probe_key,
	input  logic [KEY_W-1:0] prev_key,
	output logic [KEY_W-1:0] key_q,
	output logic             match,
	output logic [KEY_W-1:0] tail_key
);

	logic occupied;
	logic is_tail;
	logic shift_en;

	// A slot is occupied when its index lies below the fill count.
	assign occupied = (count >= CW'(IDX + 1));
	assign is_tail  = (count == CW'(IDX + 1));
	assign match    = occupied && (key_q == probe_key);
	assign tail_key = is_tail ? key_q : '0;

	// On a miss the whole row moves down; on a hit only the slots up to the matching one do.
	assign shift_en = ctrl.upd && (ctrl.miss || (hit_pos >= PW'(IDX)));

	always_ff @(posedge clk) begin
		if (shift_en) begin
			key_q <= prev_key;
		end
	end

endmodule

// ===== sv/lru_key_tracker_core.sv =====
// Top level of the least-recently-used key tracker: a row of compare-and-shift cells.
//
// Usage. Each item on the slave stream (s_tvalid, s_tready, s_tdata) is one access carrying a
// 32-bit key. Each access produces exactly one item on the master stream (m_tvalid, m_tready,
// m_tdata, m_tuser): m_tuser says whether the key was already held (hit) and whether a key was
// evicted, and m_tdata carries the evicted key, or zero when nothing was evicted.
// The cfg channel writes capacity_in_use, the most keys held before the least recently used
// one is evicted; values above CAPACITY act as CAPACITY. It is always ready and should be
// written only while the tracker is idle.
// Timing. An accepted item is compared against every occupied cell at the accepting edge; at
// the first later edge on which the output register is free, the row shifts and the result
// is registered, and the result is then offered until it is taken. The tracker holds one
// compared access at a time and takes no new access until that one has updated the row, so
// the compare and the row update of one access are never overlapped with another access.
// Reset. arst_n empties the tracker (fill count zero), sets the capacity to sixteen and
// clears the handshake state; the key cells themselves are not cleared.
// Stalls. A result waits in the output register while m_tready is low; a following access
// may be accepted meanwhile and waits, compared, until the output register is free.
module lru_key_tracker_core
	import lkt_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [KEY_W-1:0] s_tdata,   // [31:0] access_key
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [KEY_W-1:0] m_tdata,   // [31:0] evicted_key
	output logic [1:0]       m_tuser,   // [0] hit, [1] evicted_valid
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CAP_W-1:0] cfg_data   // [4:0] capacity_in_use
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = $clog2(CAPACITY);
	localparam int WW = ((CW > CAP_W) ? CW : CAP_W) + 1;

	logic [CAP_W-1:0]    capacity_q;
	logic [CW-1:0]       count_q;
	logic                pending_s1;
	logic [KEY_W-1:0]    key_s1;
	logic [CAPACITY-1:0] match_s1;
	logic                out_valid_q;
	logic                out_hit_q;
	logic                out_evict_q;
	logic [KEY_W-1:0]    out_key_q;

	logic [KEY_W-1:0]    cell_key  [CAPACITY];
	logic [KEY_W-1:0]    cell_tail [CAPACITY];
	logic [CAPACITY-1:0] cell_match;

	lkt_ctrl_t           ctrl;
	logic                accept;
	logic                upd;
	logic                hit;
	logic [PW-1:0]       hit_pos;
	logic [KEY_W-1:0]    tail_or;
	logic                evict;
	logic [KEY_W-1:0]    evicted_key;

	assign cfg_ready = 1'b1;
	assign s_tready  = !pending_s1;
	assign accept    = s_tvalid && s_tready;
	assign upd       = pending_s1 && (!out_valid_q || m_tready);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_key_q;
	assign m_tuser  = {out_evict_q, out_hit_q};

	// Keys are distinct in the row, so at most one match bit is set and an OR gives its index.
	always_comb begin
		hit_pos = '0;
		tail_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (match_s1[i]) begin
				hit_pos = hit_pos | PW'(i);
			end
			tail_or = tail_or | cell_tail[i];
		end
	end

	assign hit = |match_s1;

	// A miss evicts when the row is already at the effective capacity, which is the smaller
	// of the register and CAPACITY. With an empty row and a capacity of zero the new key
	// itself leaves at once.
	assign evict = !hit && ((WW'(count_q) >= WW'(capacity_q)) ||
		(WW'(count_q) >= WW'(CAPACITY)));
	assign evicted_key = (count_q == '0) ? key_s1 : tail_or;

	assign ctrl.upd  = upd;
	assign ctrl.miss = !hit;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		lkt_cell #(
			.IDX (g),
			.CW  (CW),
			.PW  (PW)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.count     (count_q),
			.hit_pos   (hit_pos),
			.probe_key (s_tdata),
			.prev_key  ((g == 0) ? key_s1 : cell_key[(g == 0) ? 0 : g - 1]),
			.key_q     (cell_key[g]),
			.match     (cell_match[g]),
			.tail_key  (cell_tail[g])
		);
	end

	// Control state: capacity register, fill count and the two handshake stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= CAP_RESET;
			count_q     <= '0;
			pending_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				capacity_q <= cfg_data;
			end
			if (accept) begin
				pending_s1 <= 1'b1;
			end else if (upd) begin
				pending_s1 <= 1'b0;
			end
			if (upd) begin
				out_valid_q <= 1'b1;
				if (!hit && !evict) begin
					count_q <= count_q + CW'(1);
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: the key and its match vector are captured together at acceptance; the result is captured at the row update.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_s1   <= s_tdata;
			match_s1 <= cell_match;
		end
		if (upd) begin
			out_hit_q   <= hit;
			out_evict_q <= evict;
			out_key_q   <= evict ? evicted_key : '0;
		end
	end

endmodule

// ===== verif/tb_lru_key_tracker_core.sv =====
// Self-checking testbench for the least-recently-used key tracker core.
`timescale 1ns / 100ps

module tb_lru_key_tracker_core;
	import lkt_pkg::*;

	localparam int TRACKER_DEPTH = 16;
	// Longest run of cycles with no handshake on any channel before the run is abandoned.
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int MAX_REPORTS = 40;
	localparam int ITEMS_PER_PHASE = 168;

	typedef logic [KEY_W-1:0] key_t;

	// One result item as the tracker should deliver it.
	typedef struct packed {
		logic hit;
		logic evicted_valid;
		key_t evicted_key;
	} lru_outcome_t;

	// Keeps its own recency order of the held keys and the outcomes still owed by the block.
	class lru_order_tracker;
		key_t slot[TRACKER_DEPTH+1];
		int fill;
		logic [CAP_W-1:0] capacity;
		lru_outcome_t pending_outcomes[$];
		int errors;

		function new();
			fill = 0;
			capacity = CAP_RESET;
			errors = 0;
		endfunction

		function int pending();
			return pending_outcomes.size();
		endfunction

		function void set_capacity(logic [CAP_W-1:0] value);
			capacity = value;
		endfunction

		// Slot 0 is the most recently used key, slot fill-1 the least.
		function void note_access(key_t key);
			int limit;
			int found;
			int i;
			lru_outcome_t outcome;
			limit = (capacity > TRACKER_DEPTH) ? TRACKER_DEPTH : int'(capacity);
			outcome = '0;
			found = -1;
			for (i = 0; i < fill; i++)
				if (found < 0 && slot[i] == key)
					found = i;
			if (found >= 0) begin
				for (i = found; i > 0; i--)
					slot[i] = slot[i-1];
				slot[0] = key;
				outcome.hit = 1'b1;
			end else begin
				// A miss always goes in at the front; at most one key is trimmed afterwards,
				// so a capacity lowered below the fill never shrinks the fill.
				for (i = fill; i > 0; i--)
					slot[i] = slot[i-1];
				slot[0] = key;
				fill++;
				if (fill > limit) begin
					fill--;
					outcome.evicted_valid = 1'b1;
					outcome.evicted_key = slot[fill];
				end
			end
			pending_outcomes.push_back(outcome);
		endfunction

		task report(string what);
			if (errors < MAX_REPORTS)
				$display("[%0t] mismatch: %s", $time, what);
			errors++;
		endtask

		task check_outcome(logic hit, logic evicted_valid, key_t evicted_key);
			lru_outcome_t want;
			if (pending_outcomes.size() == 0) begin
				report("result item with no access outstanding");
				return;
			end
			want = pending_outcomes.pop_front();
			if (hit !== want.hit)
				report($sformatf("hit %b, expected %b", hit, want.hit));
			if (evicted_valid !== want.evicted_valid)
				report($sformatf("evicted_valid %b, expected %b",
					evicted_valid, want.evicted_valid));
			if (evicted_key !== want.evicted_key)
				report($sformatf("evicted_key %h, expected %h",
					evicted_key, want.evicted_key));
		endtask
	endclass

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [KEY_W-1:0] s_tdata;    // [31:0] access_key
	logic             m_tvalid;
	logic             m_tready;
	logic [KEY_W-1:0] m_tdata;    // [31:0] evicted_key
	logic [1:0]       m_tuser;    // [0] hit, [1] evicted_valid
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CAP_W-1:0] cfg_data;   // [4:0] capacity_in_use

	// While set, neither side inserts gaps, so the tracker runs at its full rate.
	logic quiet;
	int idle_cycles;
	lru_order_tracker board;

	lru_key_tracker_core #(
		.CAPACITY(TRACKER_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic key_t corner_key(int sel);
		case (sel)
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			default: return 32'h7FFF_FFFF;
		endcase
	endfunction

	// Handshakes are sampled at the rising edge, where every input still holds the value driven
	// before it; the result is checked before the new access is noted, so a result can never be
	// matched against the access taken at the same edge. The watchdog sits here as well.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				board.check_outcome(m_tuser[0], m_tuser[1], m_tdata);
			if (s_tvalid && s_tready)
				board.note_access(s_tdata);
			if (cfg_valid && cfg_ready)
				board.set_capacity(cfg_data);
		end
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Result side: a random stall before each item, none while quiet.
	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 4);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Offers one access after a random gap; returns at the edge that accepted it, with the
	// valid still high so that a following access without a gap goes straight on.
	task automatic send_access(key_t key);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= key;
		do @(posedge clk); while (!s_tready);
	endtask

	// Holds the sender back until every owed result has come, then lets the row settle. The
	// count is read at the falling edge so that the monitor has finished with the rising one.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (board.pending() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [CAP_W-1:0] phase_caps[11];
		key_t pool[24];
		key_t key;
		int pool_size;
		int phase;
		int n;
		int k;

		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		quiet = 1'b0;
		idle_cycles = 0;
		arst_n = 1'b0;
		board = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Capacity zero on an empty tracker: each miss evicts the key it has just inserted.
		write_capacity(5'd0);
		send_access(32'h0000_0000);
		send_access(32'h0000_0000);

		// Full capacity: the key extremes, a promotion from the back and a hit on the front,
		// then enough fresh keys to overflow the row by one.
		write_capacity(5'd16);
		for (k = 0; k < 4; k++)
			send_access(corner_key(3 - k));
		send_access(32'h7FFF_FFFF);
		send_access(32'h7FFF_FFFF);
		for (k = 0; k < 13; k++)
			send_access(32'hA5A5_0000 | k);

		// Capacity lowered below the fill: hits evict nothing, each miss evicts one key.
		write_capacity(5'd3);
		send_access(32'hA5A5_000C);
		send_access(32'h8000_0000);
		send_access(32'h5555_5555);
		send_access(32'hAAAA_AAAA);

		// Random phases: accesses drawn mostly from a small key pool so that hits, promotions
		// and evictions of returning keys are frequent, with fresh keys mixed in.
		phase_caps = '{5'd31, 5'd1, 5'd2, 5'd16, 5'd4, 5'd0, 5'd8, 5'd17, 5'd3, 5'd12, 5'd15};
		for (phase = 0; phase < 11; phase++) begin
			write_capacity(phase_caps[phase]);
			quiet = ($urandom_range(0, 3) == 0);
			pool_size = $urandom_range(1, 24);
			for (k = 0; k < pool_size; k++)
				pool[k] = ($urandom_range(0, 7) == 0) ? corner_key($urandom_range(0, 3))
					: key_t'($urandom());
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(0, 7) == 0)
					key = $urandom();
				else
					key = pool[$urandom_range(0, pool_size - 1)];
				if (n != 0 && $urandom_range(0, 79) == 0)
					drain_results();
				send_access(key);
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
